>>> rtl/core/spc_pkg.sv
// spc_pkg: types, register codes and constants for shape_pixel_coverage.
// No dependencies; used by every file under rtl/core.
`timescale 1ns / 1ps
package spc_pkg;

	localparam int unsigned BOARD_COLS_DEF = 80;
	localparam int unsigned BOARD_ROWS_DEF = 25;
	// board dimensions go up to 256, compared in this many bits
	localparam int unsigned BOARD_CMP_W = 9;

	localparam int unsigned COL_W   = 7;
	localparam int unsigned ROW_W   = 5;
	localparam int unsigned CHAR_W  = 8;
	localparam int unsigned COORD_W = 10;
	localparam int unsigned CIRC_W  = 18;   // (2r+1)^2 for r up to 255

	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 10;

	localparam logic [CHAR_W-1:0] OUTLINE_CHAR   = 8'h2A;   // '*'
	localparam logic [CHAR_W-1:0] FILL_CHAR_RST  = 8'h2A;

	typedef enum logic [1:0] {
		SHAPE_LINE     = 2'd0,
		SHAPE_SQUARE   = 2'd1,
		SHAPE_TRIANGLE = 2'd2,
		SHAPE_CIRCLE   = 2'd3
	} shape_e_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SHAPE_KIND   = 3'd0,
		REG_ANCHOR_X     = 3'd1,
		REG_ANCHOR_Y     = 3'd2,
		REG_END_X        = 3'd3,
		REG_END_Y        = 3'd4,
		REG_SIZE         = 3'd5,
		REG_OUTLINE_MODE = 3'd6,
		REG_FILL_CHAR    = 3'd7
	} cfg_reg_e_t;

	typedef struct packed {
		shape_e_t            shape_kind;
		logic [COORD_W-1:0]  anchor_x;
		logic [COORD_W-1:0]  anchor_y;
		logic [COORD_W-1:0]  end_x;
		logic [COORD_W-1:0]  end_y;
		logic [COORD_W-1:0]  size;
		logic                outline_mode;
		logic [CHAR_W-1:0]   fill_char;
		logic [CIRC_W-1:0]   circ_hi;   // (2r+1)^2
		logic [CIRC_W-1:0]   circ_lo;   // (2r-1)^2, zero when r is zero
	} cfg_t;

	typedef struct packed {
		logic [CHAR_W-1:0] out_char;
		logic              covered;
	} result_t;

endpackage

>>> rtl/core/spc_cell_if.sv
// spc_cell_if: valid/ready channel carrying one board cell request.
// Depends on spc_pkg for field widths.
`timescale 1ns / 1ps
interface spc_cell_if;
	logic                        valid;
	logic                        ready;
	logic [spc_pkg::COL_W-1:0]   cell_col;
	logic [spc_pkg::ROW_W-1:0]   cell_row;
	logic [spc_pkg::CHAR_W-1:0]  under_char;

	modport source (output valid, cell_col, cell_row, under_char, input ready);
	modport sink   (input valid, cell_col, cell_row, under_char, output ready);
endinterface

>>> rtl/core/spc_res_if.sv
// spc_res_if: valid/ready channel carrying one cell result request.
// Depends on spc_pkg for field widths.
`timescale 1ns / 1ps
interface spc_res_if;
	logic                        valid;
	logic                        ready;
	logic [spc_pkg::CHAR_W-1:0]  out_char;
	logic                        covered;

	modport source (output valid, out_char, covered, input ready);
	modport sink   (input valid, out_char, covered, output ready);
endinterface

>>> rtl/core/spc_cfg_regs.sv
// spc_cfg_regs: figure configuration registers plus precomputed circle bounds.
// Depends on spc_pkg.
`timescale 1ns / 1ps
module spc_cfg_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [spc_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [spc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	output spc_pkg::cfg_t                    cfg
);
	import spc_pkg::*;

	cfg_t              cfg_q;
	cfg_reg_e_t        idx;
	logic [7:0]        rad;
	logic [8:0]        two_r_p1;
	logic [8:0]        two_r_m1;
	logic [CIRC_W-1:0] hi_new;
	logic [CIRC_W-1:0] lo_new;

	assign idx = cfg_reg_e_t'(cfg_idx);

	// radius = size / 2; only meaningful for positive sizes
	assign rad      = cfg_wdata[8:1];
	assign two_r_p1 = {rad, 1'b1};
	assign two_r_m1 = {rad, 1'b0} - 9'd1;
	assign hi_new   = {9'b0, two_r_p1} * {9'b0, two_r_p1};
	assign lo_new   = (rad == 8'd0) ? '0 : {9'b0, two_r_m1} * {9'b0, two_r_m1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.shape_kind   <= SHAPE_LINE;
			cfg_q.anchor_x     <= '0;
			cfg_q.anchor_y     <= '0;
			cfg_q.end_x        <= '0;
			cfg_q.end_y        <= '0;
			cfg_q.size         <= '0;
			cfg_q.outline_mode <= 1'b1;
			cfg_q.fill_char    <= FILL_CHAR_RST;
			cfg_q.circ_hi      <= CIRC_W'(1);
			cfg_q.circ_lo      <= '0;
		end else if (cfg_we) begin
			unique case (idx)
				REG_SHAPE_KIND:   cfg_q.shape_kind   <= shape_e_t'(cfg_wdata[1:0]);
				REG_ANCHOR_X:     cfg_q.anchor_x     <= cfg_wdata;
				REG_ANCHOR_Y:     cfg_q.anchor_y     <= cfg_wdata;
				REG_END_X:        cfg_q.end_x        <= cfg_wdata;
				REG_END_Y:        cfg_q.end_y        <= cfg_wdata;
				REG_SIZE: begin
					cfg_q.size    <= cfg_wdata;
					cfg_q.circ_hi <= hi_new;
					cfg_q.circ_lo <= lo_new;
				end
				REG_OUTLINE_MODE: cfg_q.outline_mode <= cfg_wdata[0];
				REG_FILL_CHAR:    cfg_q.fill_char    <= cfg_wdata[CHAR_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;
endmodule

>>> rtl/core/spc_cover.sv
// spc_cover: coverage test of one cell against the configured figure.
// Depends on spc_pkg; purely combinational, sits between the pipeline registers.
`timescale 1ns / 1ps
module spc_cover #(
	parameter int unsigned BOARD_COLS = spc_pkg::BOARD_COLS_DEF,
	parameter int unsigned BOARD_ROWS = spc_pkg::BOARD_ROWS_DEF
) (
	input  spc_pkg::cfg_t                 cfg,
	input  logic [spc_pkg::COL_W-1:0]     cell_col,
	input  logic [spc_pkg::ROW_W-1:0]     cell_row,
	input  logic [spc_pkg::CHAR_W-1:0]    under_char,
	output spc_pkg::result_t              res
);
	import spc_pkg::*;

	function automatic logic in_span(input logic signed [11:0] v,
			input logic signed [11:0] a, input logic signed [11:0] b);
		logic signed [11:0] lo;
		logic signed [11:0] hi;
		lo = (a < b) ? a : b;
		hi = (a < b) ? b : a;
		return (v >= lo) && (v <= hi);
	endfunction

	logic signed [11:0] c, r, ax, ay, ex, ey, n, nm1, dx, dy, adx, rad, ox, oy;
	logic signed [9:0]  ox10, oy10;
	logic signed [19:0] sqx, sqy;
	logic [17:0]        d2;
	logic [19:0]        d4;
	logic               outl, on_board, hit;
	logic               hit_line, hit_sq, hit_tri, hit_circ;
	logic               sq_in, tri_in, circ_in;

	assign c    = {5'b0, cell_col};
	assign r    = {7'b0, cell_row};
	assign ax   = {{2{cfg.anchor_x[9]}}, cfg.anchor_x};
	assign ay   = {{2{cfg.anchor_y[9]}}, cfg.anchor_y};
	assign ex   = {{2{cfg.end_x[9]}}, cfg.end_x};
	assign ey   = {{2{cfg.end_y[9]}}, cfg.end_y};
	assign n    = {{2{cfg.size[9]}}, cfg.size};
	assign nm1  = n - 12'sd1;
	assign dx   = c - ax;
	assign dy   = r - ay;
	assign adx  = dx[11] ? -dx : dx;
	assign outl = cfg.outline_mode;

	assign on_board = ({2'b0, cell_col} < BOARD_CMP_W'(BOARD_COLS)) &&
		({4'b0, cell_row} < BOARD_CMP_W'(BOARD_ROWS));

	// line: horizontal wins when both ends share a row
	always_comb begin
		if (ay == ey)
			hit_line = (r == ay) && in_span(c, ax, ex);
		else if (ax == ex)
			hit_line = (c == ax) && in_span(r, ay, ey);
		else
			hit_line = 1'b0;
	end

	assign sq_in  = (n > 12'sd0) && !dx[11] && (dx < n) && !dy[11] && (dy < n);
	assign hit_sq = sq_in && (!outl || dy == 12'sd0 || dy == nm1 ||
		dx == 12'sd0 || dx == nm1);

	assign tri_in  = (n > 12'sd0) && !dy[11] && (dy < n) && (adx <= dy);
	assign hit_tri = tri_in && (!outl || adx == dy || dy == nm1);

	// circle: offsets from center fit 10 bits whenever the cell is inside the box
	assign rad  = {4'b0, cfg.size[8:1]};
	assign ox   = dx - rad;
	assign oy   = dy - rad;
	assign ox10 = ox[9:0];
	assign oy10 = oy[9:0];
	assign sqx  = 20'(ox10) * 20'(ox10);
	assign sqy  = 20'(oy10) * 20'(oy10);
	assign d2   = {1'b0, sqx[16:0]} + {1'b0, sqy[16:0]};
	assign d4   = {d2, 2'b00};
	assign circ_in  = (n > 12'sd0) && !dx[11] && (dx <= n) && !dy[11] && (dy <= n);
	assign hit_circ = circ_in && (d4 <= {2'b0, cfg.circ_hi}) &&
		(!outl || d4 >= {2'b0, cfg.circ_lo});

	always_comb begin
		unique case (cfg.shape_kind)
			SHAPE_LINE:     hit = hit_line;
			SHAPE_SQUARE:   hit = hit_sq;
			SHAPE_TRIANGLE: hit = hit_tri;
			SHAPE_CIRCLE:   hit = hit_circ;
			default:        hit = 1'b0;
		endcase
	end

	always_comb begin
		res.covered  = hit && on_board;
		res.out_char = under_char;
		if (res.covered)
			res.out_char = outl ? OUTLINE_CHAR : cfg.fill_char;
	end
endmodule

>>> rtl/core/shape_pixel_coverage.sv
// shape_pixel_coverage: top level; input register, coverage logic, result register.
// Depends on spc_pkg, spc_cell_if, spc_res_if, spc_cfg_regs and spc_cover.
//
// Usage:
//  - cell channel: one request per board cell (column, row, character now there).
//  - result channel: one request per cell, in order: the new character and
//    whether the figure wrote it.
//  - config port: cfg_we/cfg_idx/cfg_wdata write one register per clock;
//    write only while no cell is in flight. Writing size also latches the
//    circle bounds (2r+1)^2 and (2r-1)^2 via one 9x9 multiply each.
//  - pipeline: two register stages, input _s1 then result _s2, before a
//    cell is offered on the result channel.
//  - throughput: one cell per clock unless result stalls; the coverage
//    test is a single pass of compares and two 10-bit circle squares (_s1 to _s2).
//  - stall: a full _s2 holds its result; _s1 still takes a cell, so the
//    pipeline backs up only when both stages are full.
//  - reset (arst_n low): both stages empty, registers to their reset values
//    (line at the origin, size 0, outline mode, fill '*').
`timescale 1ns / 1ps
module shape_pixel_coverage #(
	parameter int unsigned BOARD_COLS = spc_pkg::BOARD_COLS_DEF,
	parameter int unsigned BOARD_ROWS = spc_pkg::BOARD_ROWS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [spc_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [spc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	spc_cell_if.sink                         cells,
	spc_res_if.source                        result
);
	import spc_pkg::*;

	cfg_t               cfg;
	result_t            res_comb;

	logic               v_s1;
	logic [COL_W-1:0]   col_s1;
	logic [ROW_W-1:0]   row_s1;
	logic [CHAR_W-1:0]  under_s1;

	logic               v_s2;
	result_t            res_s2;

	logic               adv_s2;

	spc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	spc_cover #(
		.BOARD_COLS (BOARD_COLS),
		.BOARD_ROWS (BOARD_ROWS)
	) u_cover (
		.cfg        (cfg),
		.cell_col   (col_s1),
		.cell_row   (row_s1),
		.under_char (under_s1),
		.res        (res_comb)
	);

	// result stage moves when empty or drained; input stage when empty or handing off
	assign adv_s2      = !v_s2 || result.ready;
	assign cells.ready = !v_s1 || adv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (cells.ready) begin
			v_s1 <= cells.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cells.valid && cells.ready) begin
			col_s1   <= cells.cell_col;
			row_s1   <= cells.cell_row;
			under_s1 <= cells.under_char;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && v_s1) begin
			res_s2 <= res_comb;
		end
	end

	assign result.valid    = v_s2;
	assign result.out_char = res_s2.out_char;
	assign result.covered  = res_s2.covered;

	// an uncovered cell passes its own character through
	a_pass_through: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && adv_s2) |=> (result.valid &&
			(result.covered || result.out_char == $past(under_s1))))
		else $error("uncovered cell lost its character");

	// cells off the board are never written
	a_off_board: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && adv_s2 && (({2'b0, col_s1} >= BOARD_CMP_W'(BOARD_COLS)) ||
			({4'b0, row_s1} >= BOARD_CMP_W'(BOARD_ROWS)))) |=> !result.covered)
		else $error("off-board cell reported covered");

	// both stages full and stalled: no new cell may enter
	a_full_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && v_s2 && !result.ready) |-> !cells.ready)
		else $error("cell accepted into a full pipeline");
endmodule

>>> tb/spc_checker.sv
// spc_checker: watches the cell and result channels of shape_pixel_coverage and
// checks every result against a prediction made from shadowed config registers.
// Depends on spc_pkg, spc_cell_if and spc_res_if.
`timescale 1ns / 1ps
module spc_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [spc_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [spc_pkg::CFG_DATA_W-1:0] cfg_wdata,
	spc_cell_if                            cells,
	spc_res_if                             results,
	output int                             mismatches,
	output int                             outstanding,
	output int                             cells_checked,
	output int                             cells_drawn
);
	import spc_pkg::*;

	localparam int REPORT_LIMIT = 10;

	// shadow of the figure registers
	shape_e_t            fig_kind;
	logic [COORD_W-1:0]  fig_ax;
	logic [COORD_W-1:0]  fig_ay;
	logic [COORD_W-1:0]  fig_ex;
	logic [COORD_W-1:0]  fig_ey;
	logic [COORD_W-1:0]  fig_size;
	logic                fig_outline;
	logic [CHAR_W-1:0]   fig_fill;

	result_t pending_draws[$];
	result_t want;

	function automatic bit figure_covers(int c, int r);
		int ax, ay, ex, ey, n, dx, dy, adx, rad, ox, oy, d4, hi, lo;
		ax = int'($signed(fig_ax));
		ay = int'($signed(fig_ay));
		ex = int'($signed(fig_ex));
		ey = int'($signed(fig_ey));
		n  = int'($signed(fig_size));
		dx = c - ax;
		dy = r - ay;
		adx = (dx < 0) ? -dx : dx;
		case (fig_kind)
			SHAPE_LINE: begin
				if (ay == ey)
					return r == ay && c >= ((ax < ex) ? ax : ex) && c <= ((ax < ex) ? ex : ax);
				if (ax == ex)
					return c == ax && r >= ((ay < ey) ? ay : ey) && r <= ((ay < ey) ? ey : ay);
				return 1'b0;
			end
			SHAPE_SQUARE: begin
				if (n <= 0 || dx < 0 || dx >= n || dy < 0 || dy >= n)
					return 1'b0;
				if (!fig_outline)
					return 1'b1;
				return dy == 0 || dy == n - 1 || dx == 0 || dx == n - 1;
			end
			SHAPE_TRIANGLE: begin
				if (n <= 0 || dy < 0 || dy >= n || adx > dy)
					return 1'b0;
				if (!fig_outline)
					return 1'b1;
				return adx == dy || dy == n - 1;
			end
			default: begin
				// circle: integer form of the radius test, bounding box is inclusive
				if (n <= 0 || dx < 0 || dx > n || dy < 0 || dy > n)
					return 1'b0;
				rad = n / 2;
				ox = dx - rad;
				oy = dy - rad;
				d4 = 4 * (ox * ox + oy * oy);
				hi = (2 * rad + 1) * (2 * rad + 1);
				if (d4 > hi)
					return 1'b0;
				if (!fig_outline || rad < 1)
					return 1'b1;
				lo = (2 * rad - 1) * (2 * rad - 1);
				return d4 >= lo;
			end
		endcase
	endfunction

	function automatic result_t draw_cell(logic [COL_W-1:0] col, logic [ROW_W-1:0] row,
		logic [CHAR_W-1:0] under);
		result_t res;
		res.covered = (col < BOARD_COLS_DEF) && (row < BOARD_ROWS_DEF)
			&& figure_covers(int'(col), int'(row));
		res.out_char = res.covered ? (fig_outline ? OUTLINE_CHAR : fig_fill) : under;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fig_kind      = SHAPE_LINE;
			fig_ax        = '0;
			fig_ay        = '0;
			fig_ex        = '0;
			fig_ey        = '0;
			fig_size      = '0;
			fig_outline   = 1'b1;
			fig_fill      = FILL_CHAR_RST;
			pending_draws.delete();
			mismatches    = 0;
			outstanding   = 0;
			cells_checked = 0;
			cells_drawn   = 0;
		end else begin
			// retire first: a result leaving this edge belongs to an older cell
			if (results.valid && results.ready) begin
				if (pending_draws.size() == 0) begin
					if (mismatches < REPORT_LIMIT)
						$display("%0t: result with no cell waiting: char %02h covered %0b",
							$time, results.out_char, results.covered);
					mismatches++;
				end else begin
					want = pending_draws.pop_front();
					cells_checked++;
					if (results.covered)
						cells_drawn++;
					if (results.out_char !== want.out_char || results.covered !== want.covered) begin
						if (mismatches < REPORT_LIMIT)
							$display("%0t: mismatch: expected char %02h covered %0b, got %02h %0b",
								$time, want.out_char, want.covered,
								results.out_char, results.covered);
						mismatches++;
					end
				end
			end
			if (cells.valid && cells.ready)
				pending_draws.insert(pending_draws.size(),
					draw_cell(cells.cell_col, cells.cell_row, cells.under_char));
			if (cfg_we) begin
				case (cfg_reg_e_t'(cfg_idx))
					REG_SHAPE_KIND:   fig_kind    = shape_e_t'(cfg_wdata[1:0]);
					REG_ANCHOR_X:     fig_ax      = cfg_wdata;
					REG_ANCHOR_Y:     fig_ay      = cfg_wdata;
					REG_END_X:        fig_ex      = cfg_wdata;
					REG_END_Y:        fig_ey      = cfg_wdata;
					REG_SIZE:         fig_size    = cfg_wdata;
					REG_OUTLINE_MODE: fig_outline = cfg_wdata[0];
					REG_FILL_CHAR:    fig_fill    = cfg_wdata[CHAR_W-1:0];
					default: ;
				endcase
			end
			outstanding = pending_draws.size();
		end
	end

endmodule

>>> tb/tb.sv
// tb: top of the shape_pixel_coverage testbench; clock, reset, config writes,
// cell stimulus, result back-pressure and the verdict. Checking is in spc_checker.
// Depends on spc_pkg, spc_cell_if, spc_res_if, spc_checker and the block itself.
`timescale 1ns / 1ps
module tb;
	import spc_pkg::*;

	localparam int RANDOM_FIGURES   = 16;
	localparam int CELLS_PER_FIGURE = 33;
	localparam int HOLD_CYCLES      = 40;     // long receiver hold-off
	localparam int DRAIN_CYCLES     = 4;      // two pipe stages plus margin
	localparam int STALL_LIMIT      = 2000;   // cycles with no request moving
	localparam int IDLE_PCT         = 6;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	int idle_pct     = IDLE_PCT;   // shared by sender and receiver
	bit hold_req     = 1'b0;       // asks the receiver for one long hold-off
	int quiet_cycles = 0;
	int figures_set  = 0;

	// what the stimulus last wrote, used only to aim cells at the figure
	shape_e_t aim_kind = SHAPE_LINE;
	int aim_ax   = 0;
	int aim_ay   = 0;
	int aim_ex   = 0;
	int aim_ey   = 0;
	int aim_size = 0;

	int mismatches;
	int outstanding;
	int cells_checked;
	int cells_drawn;

	spc_cell_if cell_ch();
	spc_res_if  res_ch();

	shape_pixel_coverage uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.cells     (cell_ch),
		.result    (res_ch)
	);

	spc_checker chk (clk, arst_n, cfg_we, cfg_idx, cfg_wdata, cell_ch, res_ch,
		mismatches, outstanding, cells_checked, cells_drawn);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// watchdog: any request moving on either channel resets the count
	always @(posedge clk) begin
		if ((cell_ch.valid && cell_ch.ready) || (res_ch.valid && res_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("watchdog: no request moved for %0d cycles, %0d results still due",
				STALL_LIMIT, outstanding);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// result side: random ready drops, plus one long hold-off on request so the
	// two pipe stages fill and the block has to stall the cell channel
	initial begin
		res_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				res_ch.ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
			end else begin
				res_ch.ready = ($urandom_range(99) >= idle_pct);
			end
		end
	end

	task automatic put_reg(input cfg_reg_e_t idx, input int val);
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_idx   = idx;
		cfg_wdata = val[CFG_DATA_W-1:0];
		@(negedge clk);
		cfg_we    = 1'b0;
	endtask

	// writes all eight registers; narrow ones get junk above their width,
	// which the block has to mask off
	task automatic set_figure(input shape_e_t kind, input int ax, ay, ex, ey, n,
		input bit outl, input int fch);
		put_reg(REG_SHAPE_KIND, int'(kind) | int'($urandom_range(255) << 2));
		put_reg(REG_ANCHOR_X, ax);
		put_reg(REG_ANCHOR_Y, ay);
		put_reg(REG_END_X, ex);
		put_reg(REG_END_Y, ey);
		put_reg(REG_SIZE, n);
		put_reg(REG_OUTLINE_MODE, int'(outl) | int'($urandom_range(511) << 1));
		put_reg(REG_FILL_CHAR, (fch & 8'hFF) | int'($urandom_range(3) << 8));
		aim_kind = kind;
		aim_ax   = ax;
		aim_ay   = ay;
		aim_ex   = ex;
		aim_ey   = ey;
		aim_size = n;
		figures_set++;
	endtask

	// offer one cell; valid stays high into the next call unless a gap is rolled
	task automatic send_cell(input int col, row, ch);
		@(negedge clk);
		if ($urandom_range(99) < idle_pct) begin
			cell_ch.valid = 1'b0;
			repeat ($urandom_range(4, 1)) @(negedge clk);
		end
		cell_ch.valid      = 1'b1;
		cell_ch.cell_col   = col[COL_W-1:0];
		cell_ch.cell_row   = row[ROW_W-1:0];
		cell_ch.under_char = ch[CHAR_W-1:0];
		do
			@(posedge clk);
		while (!cell_ch.ready);
	endtask

	// drop valid, wait for every result, then let the pipe go quiet before
	// any register write
	task automatic settle();
		@(negedge clk);
		cell_ch.valid = 1'b0;
		wait (outstanding == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// mostly cells in and just around the figure's box, clamped onto the
	// board; the rest anywhere the fields reach, off-board cells included
	task automatic aim_cell(output int col, output int row);
		int lo_x, hi_x, lo_y, hi_y, m;
		if ($urandom_range(99) < 20) begin
			col = int'($urandom_range(127));
			row = int'($urandom_range(31));
		end else begin
			if (aim_kind == SHAPE_LINE) begin
				lo_x = (aim_ax < aim_ex) ? aim_ax : aim_ex;
				hi_x = (aim_ax < aim_ex) ? aim_ex : aim_ax;
				lo_y = (aim_ay < aim_ey) ? aim_ay : aim_ey;
				hi_y = (aim_ay < aim_ey) ? aim_ey : aim_ay;
			end else begin
				m    = (aim_size > 0) ? aim_size : 1;
				lo_x = (aim_kind == SHAPE_TRIANGLE) ? aim_ax - m : aim_ax;
				hi_x = aim_ax + m;
				lo_y = aim_ay;
				hi_y = aim_ay + m;
			end
			col = lo_x - 1 + int'($urandom_range(hi_x - lo_x + 2));
			row = lo_y - 1 + int'($urandom_range(hi_y - lo_y + 2));
			if (col < 0) col = 0;
			if (col > int'(BOARD_COLS_DEF) - 1) col = int'(BOARD_COLS_DEF) - 1;
			if (row < 0) row = 0;
			if (row > int'(BOARD_ROWS_DEF) - 1) row = int'(BOARD_ROWS_DEF) - 1;
		end
	endtask

	// figure for random phase p: a few fixed extremes, then every shape in
	// both drawing modes, with anchors near the board and mostly small sizes
	task automatic random_figure(input int p);
		shape_e_t kind;
		int ax, ay, ex, ey, n, pick;
		bit outl;
		kind = shape_e_t'($urandom_range(3));
		outl = $urandom_range(1);
		if (p >= 4) begin
			kind = shape_e_t'(p % 4);
			outl = ((p / 4) % 2 == 1);
		end
		ax = int'($urandom_range(99)) - 10;
		ay = int'($urandom_range(44)) - 10;
		if ($urandom_range(9) == 0) begin
			ax = int'($urandom_range(1023)) - 512;
			ay = int'($urandom_range(1023)) - 512;
		end
		if ($urandom_range(4) == 0)
			n = int'($urandom_range(1023)) - 512;
		else
			n = int'($urandom_range(24)) - 2;
		// lines: mostly horizontal or vertical, now and then diagonal
		ex = int'($urandom_range(99)) - 10;
		ey = int'($urandom_range(44)) - 10;
		pick = $urandom_range(99);
		if (pick < 45)
			ey = ay;
		else if (pick < 90)
			ex = ax;
		case (p)
			1: set_figure(SHAPE_SQUARE, -512, -512, 511, 511, 511, 1'b1, 255);
			2: set_figure(SHAPE_TRIANGLE, 511, -512, -512, 511, -512, 1'b0, 0);
			3: begin
				ey = int'($urandom_range(BOARD_ROWS_DEF - 1));
				set_figure(SHAPE_LINE, -512, ey, 511, ey, n, 1'b0, $urandom_range(255));
			end
			default: set_figure(kind, ax, ay, ex, ey, n, outl, $urandom_range(255));
		endcase
	endtask

	initial begin
		int col, row;
		cell_ch.valid      = 1'b0;
		cell_ch.cell_col   = '0;
		cell_ch.cell_row   = '0;
		cell_ch.under_char = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset figure: a one-cell line at the origin drawn with '*'
		send_cell(0, 0, 8'h41);
		send_cell(1, 0, 8'h00);
		send_cell(0, 1, 8'hFF);
		send_cell(79, 24, 8'h00);
		// cells off the board never get drawn
		send_cell(80, 0, 8'h55);
		send_cell(127, 31, 8'hAA);
		settle();

		// filled square: corners in, one past the far corner out
		set_figure(SHAPE_SQUARE, 2, 3, 0, 0, 4, 1'b0, 8'hFF);
		send_cell(2, 3, 8'h00);
		send_cell(5, 6, 8'h01);
		send_cell(6, 6, 8'h02);
		send_cell(3, 4, 8'h03);
		settle();

		// outlined square: interior kept, border drawn
		set_figure(SHAPE_SQUARE, 2, 3, 0, 0, 4, 1'b1, 8'hFF);
		send_cell(3, 4, 8'h00);
		send_cell(5, 4, 8'h00);
		settle();

		// outlined triangle: apex, hollow interior, slanted side, full last row
		set_figure(SHAPE_TRIANGLE, 10, 0, 0, 0, 3, 1'b1, 8'h2B);
		send_cell(10, 0, 8'h20);
		send_cell(10, 1, 8'h20);
		send_cell(9, 1, 8'h20);
		send_cell(11, 2, 8'h20);
		settle();

		// circle of radius zero: no inner bound in outline mode
		set_figure(SHAPE_CIRCLE, 5, 5, 0, 0, 1, 1'b1, 8'h00);
		send_cell(5, 5, 8'h2E);
		send_cell(6, 6, 8'h2E);
		settle();

		// outlined circle, diameter 9: rim drawn, center kept
		set_figure(SHAPE_CIRCLE, 0, 0, 0, 0, 9, 1'b1, 8'h00);
		send_cell(4, 0, 8'h2E);
		send_cell(4, 4, 8'h2E);
		settle();

		// diagonal line draws nothing, even at its own end points
		set_figure(SHAPE_LINE, 0, 0, 5, 5, 0, 1'b0, 8'h78);
		send_cell(0, 0, 8'h2E);
		send_cell(3, 3, 8'h2E);
		settle();

		// vertical line given bottom-up, filled with character zero
		set_figure(SHAPE_LINE, 3, 10, 3, 2, 0, 1'b0, 8'h00);
		send_cell(3, 5, 8'h2E);
		send_cell(3, 11, 8'h2E);
		settle();

		// most negative size draws nothing
		set_figure(SHAPE_SQUARE, 0, 0, 0, 0, -512, 1'b0, 8'h41);
		send_cell(0, 0, 8'h2E);
		settle();

		// random figures; a stretch of phases runs with no idling on either
		// side, and one phase starts under a long receiver hold-off
		for (int p = 0; p < RANDOM_FIGURES; p++) begin
			idle_pct = (p >= 5 && p <= 7) ? 0 : IDLE_PCT;
			random_figure(p);
			if (p == 10)
				hold_req = 1'b1;
			for (int i = 0; i < CELLS_PER_FIGURE; i++) begin
				aim_cell(col, row);
				send_cell(col, row, $urandom_range(255));
			end
			settle();
		end

		repeat (2 * DRAIN_CYCLES) @(posedge clk);
		$display("Checked %0d cell results over %0d figure settings, %0d cells drawn;",
			cells_checked, figures_set, cells_drawn);
		$display("all four shapes in outline and fill, extreme registers, off-board cells.");
		if (mismatches == 0 && outstanding == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
